[hdl/positional_list_store_unit_assert.svh]
// Assertion macros for the positional list store.
// Expects a clock named clk and a synchronous reset named rst in scope.
`ifndef POSITIONAL_LIST_STORE_UNIT_ASSERT_SVH
`define POSITIONAL_LIST_STORE_UNIT_ASSERT_SVH

// expr holds at every edge outside reset
`define PLS_ASSERT_ALWAYS(label, expr) \
  label: assert property (@(posedge clk) disable iff (rst) (expr)) \
    else $error("assertion failed: label");

// cond implies expr in the same cycle
`define PLS_ASSERT_IMPL(label, cond, expr) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (expr)) \
    else $error("assertion failed: label");

// cond implies expr in the next cycle
`define PLS_ASSERT_NEXT(label, cond, expr) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (expr)) \
    else $error("assertion failed: label");

`endif

[hdl/pls_pkg.sv]
// Shared types, codes and helpers for the positional list store.
// No dependencies; used by pls_cell and positional_list_store_unit.
package pls_pkg;

  localparam int DEPTH  = 64;
  localparam int VAL_W  = 32;
  localparam int IDX_W  = $clog2(DEPTH);
  localparam int CNT_W  = $clog2(DEPTH + 1);
  localparam int REQ_W  = 3;
  localparam int STAT_W = 3;

  // request kinds
  localparam logic [REQ_W-1:0] REQ_INSERT = 3'd0;
  localparam logic [REQ_W-1:0] REQ_REMOVE = 3'd1;
  localparam logic [REQ_W-1:0] REQ_SEARCH = 3'd2;
  localparam logic [REQ_W-1:0] REQ_FIRST  = 3'd3;
  localparam logic [REQ_W-1:0] REQ_CLEAR  = 3'd4;

  // status codes
  localparam logic [STAT_W-1:0] ST_OK       = 3'd0;
  localparam logic [STAT_W-1:0] ST_BADPOS   = 3'd1;
  localparam logic [STAT_W-1:0] ST_EMPTY    = 3'd2;
  localparam logic [STAT_W-1:0] ST_NOTFOUND = 3'd3;
  localparam logic [STAT_W-1:0] ST_FULL     = 3'd4;

  typedef enum logic [2:0] {
    OP_NONE,
    OP_INSERT,
    OP_REMOVE,
    OP_SEARCH,
    OP_PEEK
  } cell_op_t;

  // command broadcast to every cell
  typedef struct packed {
    cell_op_t         op;
    logic [CNT_W-1:0] pos;
    logic [CNT_W-1:0] count;
    logic [VAL_W-1:0] value;
  } cell_cmd_t;

  typedef enum logic {
    SM_IDLE,
    SM_SCAN
  } state_t;

  // index of the lowest set bit; zero when none is set
  function automatic logic [IDX_W-1:0] first_hit(input logic [DEPTH-1:0] hits);
    logic [IDX_W-1:0] idx;
    idx = '0;
    for (int i = DEPTH - 1; i >= 0; i--) begin
      if (hits[i]) begin
        idx = IDX_W'(i);
      end
    end
    return idx;
  endfunction

endpackage

[hdl/pls_cell.sv]
// One storage cell of the list chain: holds one value, shifts with its neighbors,
// compares against the search key. Depends on pls_pkg.
module pls_cell
  import pls_pkg::*;
(
  input  logic             clk,
  input  logic [CNT_W-1:0] idx,
  input  cell_cmd_t        cmd,
  input  logic [VAL_W-1:0] left_value,
  input  logic [VAL_W-1:0] right_value,
  output logic [VAL_W-1:0] value,
  output logic             hit,
  output logic [VAL_W-1:0] pick
);

  logic [VAL_W-1:0] value_next;
  logic             in_list;

  assign in_list = idx < cmd.count;

  always_comb begin
    value_next = value;
    case (cmd.op)
      OP_INSERT: begin
        // open a slot at pos: later entries move one place back
        if (idx == cmd.pos) begin
          value_next = cmd.value;
        end else if (idx > cmd.pos && idx <= cmd.count) begin
          value_next = left_value;
        end
      end
      OP_REMOVE: begin
        if (idx >= cmd.pos && (idx + CNT_W'(1)) < cmd.count) begin
          value_next = right_value;
        end
      end
      default: value_next = value;
    endcase
  end

  always_ff @(posedge clk) begin
    value <= value_next;
    if (cmd.op != OP_NONE) begin
      hit  <= (cmd.op == OP_SEARCH) && in_list && (value == cmd.value);
      pick <= (idx == cmd.pos) ? value : '0;
    end
  end

endmodule

[hdl/positional_list_store_unit.sv]
// Top level of the positional list store: request decode, row of pls_cell,
// hit encoder and output register. Depends on pls_pkg and pls_cell.
//
//  channel | handshake            | payload
//  --------+----------------------+-----------------------------------------------
//  in      | in_valid / in_ready  | req_type, position, item_value
//  out     | out_valid / out_ready| status, value_out, found_position, list_size
//
// On the accept edge all cells shift or compare at once; in the scan state, once the
// output register is free, the hit and pick vectors are encoded into it.
// One request is in flight at a time, bounded by the shared hit/pick vectors.
// Reset clears the count, state and output valid; cell contents are left as is.
// A stalled output holds the scan state; a new request is taken while a finished
// result waits in the output register.
`include "positional_list_store_unit_assert.svh"

module positional_list_store_unit
  import pls_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     in_valid,
  output logic                     in_ready,
  input  logic [REQ_W-1:0]         req_type,
  input  logic [CNT_W-1:0]         position,
  input  logic signed [VAL_W-1:0]  item_value,
  output logic                     out_valid,
  input  logic                     out_ready,
  output logic [STAT_W-1:0]        status,
  output logic signed [VAL_W-1:0]  value_out,
  output logic [IDX_W-1:0]         found_position,
  output logic [CNT_W-1:0]         list_size
);

  state_t            state, state_next;
  logic [CNT_W-1:0]  count, count_next;
  logic [REQ_W-1:0]  kind;
  logic [STAT_W-1:0] acc_status, acc_status_next;
  cell_cmd_t         cmd;
  logic              in_beat, out_load;

  logic [VAL_W-1:0]  cell_value [DEPTH];
  logic [VAL_W-1:0]  cell_pick  [DEPTH];
  logic [DEPTH-1:0]  hits;
  logic [VAL_W-1:0]  pick_any;

  assign in_ready = (state == SM_IDLE);
  assign in_beat  = in_valid && in_ready;
  assign out_load = (state == SM_SCAN) && (!out_valid || out_ready);

  // decode the request against the current count
  always_comb begin
    cmd.op          = OP_NONE;
    cmd.pos         = position;
    cmd.count       = count;
    cmd.value       = item_value;
    count_next      = count;
    acc_status_next = ST_OK;
    if (in_beat) begin
      unique case (req_type)
        REQ_INSERT: begin
          if (position > count) begin
            acc_status_next = ST_BADPOS;
          end else if (count == CNT_W'(DEPTH)) begin
            acc_status_next = ST_FULL;
          end else begin
            cmd.op     = OP_INSERT;
            count_next = count + CNT_W'(1);
          end
        end
        REQ_REMOVE: begin
          if (count == '0) begin
            acc_status_next = ST_EMPTY;
          end else if (position >= count) begin
            acc_status_next = ST_BADPOS;
          end else begin
            cmd.op     = OP_REMOVE;
            count_next = count - CNT_W'(1);
          end
        end
        REQ_SEARCH: cmd.op = OP_SEARCH;
        REQ_FIRST: begin
          cmd.pos = '0;
          if (count == '0) begin
            acc_status_next = ST_EMPTY;
          end else begin
            cmd.op = OP_PEEK;
          end
        end
        REQ_CLEAR: count_next = '0;
        default:   acc_status_next = ST_OK;
      endcase
    end
  end

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic [VAL_W-1:0] left_value, right_value;
    logic             hit;
    if (i == 0) begin : g_head
      assign left_value = '0;
    end else begin : g_body
      assign left_value = cell_value[i-1];
    end
    if (i == DEPTH - 1) begin : g_tail
      assign right_value = '0;
    end else begin : g_link
      assign right_value = cell_value[i+1];
    end
    pls_cell u_cell (
      .clk         (clk),
      .idx         (CNT_W'(i)),
      .cmd         (cmd),
      .left_value  (left_value),
      .right_value (right_value),
      .value       (cell_value[i]),
      .hit         (hit),
      .pick        (cell_pick[i])
    );
    assign hits[i] = hit;
  end

  always_comb begin
    pick_any = '0;
    for (int i = 0; i < DEPTH; i++) begin
      pick_any = pick_any | cell_pick[i];
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      SM_IDLE: if (in_beat) state_next = SM_SCAN;
      SM_SCAN: if (out_load) state_next = SM_IDLE;
      default: state_next = SM_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= SM_IDLE;
      count     <= '0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      count <= count_next;
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_beat) begin
      kind       <= req_type;
      acc_status <= acc_status_next;
    end
    if (out_load) begin
      list_size      <= count;
      found_position <= '0;
      value_out      <= '0;
      status         <= acc_status;
      if (kind == REQ_SEARCH) begin
        if (|hits) begin
          found_position <= first_hit(hits);
        end else begin
          status <= ST_NOTFOUND;
        end
      end else if (acc_status == ST_OK && (kind == REQ_REMOVE || kind == REQ_FIRST)) begin
        value_out <= pick_any;
      end
    end
  end

  `PLS_ASSERT_ALWAYS(a_count_bound, count <= CNT_W'(DEPTH))
  `PLS_ASSERT_IMPL(a_out_from_scan, $rose(out_valid), $past(state == SM_SCAN))
  `PLS_ASSERT_NEXT(a_count_idle, !in_beat, $stable(count))
  `PLS_ASSERT_IMPL(a_found_in_list, out_valid && found_position != '0,
                   CNT_W'(found_position) < list_size)

endmodule
